### design/prf_pkg.sv
// Shared types and constants for the page frame replacement block.
// No dependencies; imported by prf_cell, page_frame_replacement and tb_top.
package prf_pkg;

  localparam int PAGE_W      = 6;   // page field on the input stream
  localparam int FRAME_W     = 3;   // frame field on the result stream
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int STAMP_W     = 32;
  // probe and update records are sized for the largest configuration
  localparam int PG_IDX_W    = 12;  // up to 4096 pages
  localparam int FR_IDX_W    = 6;   // up to 64 frames

  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [PG_IDX_W-1:0] page;
    logic                hit;
    logic [FR_IDX_W-1:0] hit_idx;
    logic                free_found;
    logic [FR_IDX_W-1:0] free_idx;
    logic                best_valid;
    logic [STAMP_W-1:0]  best_stamp;
    logic [FR_IDX_W-1:0] best_idx;
  } probe_t;

  // write-back broadcast to the cells
  typedef struct packed {
    logic                en;
    logic                load;
    logic                stamp_en;
    logic [FR_IDX_W-1:0] idx;
    logic [PG_IDX_W-1:0] page;
    logic [STAMP_W-1:0]  stamp;
  } upd_t;

endpackage

### design/prf_cell.sv
// One frame cell: owner page, valid flag and use stamp of a single frame.
// Updates the passing search record and registers it for the next cell. Uses prf_pkg.
module prf_cell #(
  parameter int IDX  = 0,
  parameter int PG_W = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  prf_pkg::probe_t probe_i,
  output prf_pkg::probe_t probe_o,
  input  prf_pkg::upd_t   upd_i
);
  import prf_pkg::*;

  localparam logic [FR_IDX_W-1:0] MY_IDX = FR_IDX_W'(IDX);

  logic               owner_vld_r;
  logic [PG_W-1:0]    owner_page_r;
  logic [STAMP_W-1:0] stamp_r;
  probe_t             probe_r;
  probe_t             probe_nxt;
  logic               sel;

  assign sel = upd_i.en && (upd_i.idx == MY_IDX);

  always_comb begin
    probe_nxt = probe_i;
    if (owner_vld_r && (owner_page_r == probe_i.page[PG_W-1:0])) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.hit_idx = MY_IDX;
    end
    // lowest free frame wins
    if (!owner_vld_r && !probe_i.free_found) begin
      probe_nxt.free_found = 1'b1;
      probe_nxt.free_idx   = MY_IDX;
    end
    // strict less-than keeps the lowest index on ties
    if (!probe_i.best_valid || (stamp_r < probe_i.best_stamp)) begin
      probe_nxt.best_valid = 1'b1;
      probe_nxt.best_stamp = stamp_r;
      probe_nxt.best_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) probe_r <= '0;
    else probe_r <= probe_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_vld_r <= 1'b0;
      stamp_r     <= '0;
    end else if (sel) begin
      if (upd_i.load) owner_vld_r <= 1'b1;
      if (upd_i.stamp_en) stamp_r <= upd_i.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && upd_i.load) owner_page_r <= upd_i.page[PG_W-1:0];
  end

  assign probe_o = probe_r;

endmodule

### design/page_frame_replacement.sv
// Page frame replacement (LRU / FIFO) top level: chain of frame cells plus
// result and write-back control. Depends on prf_pkg and prf_cell.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in_     | sink      | in_tvalid / in_tready  | in_tdata[5:0] page
//  out_    | source    | out_tvalid / out_tready| out_tdata[2:0] frame, [3] miss
//  cfg_    | sink      | cfg_wr_en              | cfg_wr_data policy_mode
//
//  One reference at a time: a transaction walks the cells one per cycle, then
//  the decision register and the write-back. The result is registered by the
//  write-back and in_tready returns with it, so a new reference is taken only
//  once the last one has been written back.
//  Reset: all frames free, stamps, access clock and FIFO pointer zero, LRU policy.
//  A stalled result holds the write-back; the chain is free again once it lands.
module page_frame_replacement #(
  parameter int PAGE_COUNT  = 64,
  parameter int FRAME_COUNT = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [prf_pkg::IN_TDATA_W-1:0]  in_tdata,   // [5:0] page
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prf_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] frame, [3] miss
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data // policy_mode
);
  import prf_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_COUNT - 1);

  policy_t             mode_r;
  logic                busy_r;
  logic [FW-1:0]       fifo_r;
  logic [STAMP_W-1:0]  clock_r;
  logic [STAMP_W-1:0]  clock_nxt;

  logic                pend_vld_r;
  logic [FW-1:0]       pend_idx_r;
  logic [FW-1:0]       pend_idx_nxt;
  logic                pend_miss_r;
  logic [PW-1:0]       pend_page_r;

  logic                out_vld_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic                out_miss_r;

  logic                accept;
  logic                commit;
  logic [PW-1:0]       page_in;
  probe_t              launch;
  probe_t              chain [FRAME_COUNT];
  probe_t              last;
  logic [FRAME_COUNT-1:0] chain_vld;
  upd_t                upd;
  logic [FR_IDX_W-1:0] lru_victim;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign commit    = pend_vld_r && (!out_vld_r || out_tready);

  assign page_in = PW'(in_tdata[PAGE_W-1:0] % PAGE_COUNT);

  always_comb begin
    launch       = '0;
    launch.valid = accept;
    launch.page  = PG_IDX_W'(page_in);
  end

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      prf_cell #(.IDX(g), .PG_W(PW)) u_cell (
        .clk(clk), .rst_n(rst_n), .probe_i(launch), .probe_o(chain[g]), .upd_i(upd)
      );
    end else begin : g_body
      prf_cell #(.IDX(g), .PG_W(PW)) u_cell (
        .clk(clk), .rst_n(rst_n), .probe_i(chain[g-1]), .probe_o(chain[g]), .upd_i(upd)
      );
    end
    assign chain_vld[g] = chain[g].valid;
  end

  assign last       = chain[FRAME_COUNT-1];
  assign lru_victim = last.free_found ? last.free_idx : last.best_idx;

  always_comb begin
    if (last.hit) pend_idx_nxt = last.hit_idx[FW-1:0];
    else if (mode_r == POLICY_LRU) pend_idx_nxt = lru_victim[FW-1:0];
    else pend_idx_nxt = fifo_r;
  end

  assign clock_nxt = clock_r + STAMP_W'(1);

  always_comb begin
    upd.en       = commit;
    upd.load     = pend_miss_r;
    upd.stamp_en = (mode_r == POLICY_LRU);
    upd.idx      = FR_IDX_W'(pend_idx_r);
    upd.page     = PG_IDX_W'(pend_page_r);
    upd.stamp    = clock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= POLICY_LRU;
      busy_r     <= 1'b0;
      fifo_r     <= '0;
      clock_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= policy_t'(cfg_wr_data);
      if (accept) busy_r <= 1'b1;
      else if (commit) busy_r <= 1'b0;
      if (last.valid) pend_vld_r <= 1'b1;
      else if (commit) pend_vld_r <= 1'b0;
      if (commit) begin
        out_vld_r <= 1'b1;
        if (mode_r == POLICY_LRU) clock_r <= clock_nxt;
        else if (pend_miss_r) fifo_r <= (pend_idx_r == LAST_FRAME) ? '0 : pend_idx_r + 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      pend_idx_r  <= pend_idx_nxt;
      pend_miss_r <= !last.hit;
      pend_page_r <= last.page[PW-1:0];
    end
    if (commit) begin
      out_frame_r <= FRAME_W'(pend_idx_r);
      out_miss_r  <= pend_miss_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - FRAME_W - 1)'(0), out_miss_r, out_frame_r};

  // at most one reference in flight across the chain and the decision stage
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({chain_vld, pend_vld_r}))
    else $error("more than one reference in flight");

  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    ((chain_vld != '0) || pend_vld_r) |-> busy_r)
    else $error("reference in flight while input is open");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_vld_r && !pend_vld_r && !busy_r))
    else $error("write-back did not present a result");

endmodule

### tb/tb_top.sv
// Self-checking bench for page_frame_replacement: directed table, then random
// page references under both replacement policies with idling on both streams.
// Depends on prf_pkg and the page_frame_replacement RTL.
`timescale 1ns / 1ps

module tb_top;
  import prf_pkg::*;

  localparam int PAGES  = 64;
  localparam int FRAMES = 8;
  localparam int DRAIN_CYCLES = FRAMES + 4;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               miss;
  } lookup_t;

  typedef enum logic {
    ROW_REF = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [PAGE_W-1:0]  page;    // page for ROW_REF, policy in bit 0 for ROW_CFG
    logic               typed;
    logic [FRAME_W-1:0] frame;
    logic               miss;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [5:0] page
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [2:0] frame, [3] miss
  logic                   cfg_wr_en;
  logic                   cfg_wr_data;

  page_frame_replacement #(
    .PAGE_COUNT (PAGES),
    .FRAME_COUNT(FRAMES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the mapping tables
  logic               page_mapped [PAGES];
  logic [FRAME_W-1:0] page_frame  [PAGES];
  logic               frame_busy  [FRAMES];
  logic [PAGE_W-1:0]  frame_page  [FRAMES];
  logic [STAMP_W-1:0] frame_last_use [FRAMES];
  logic [FRAME_W-1:0] rr_next;
  logic [STAMP_W-1:0] use_clock;
  policy_t            policy;

  lookup_t pending_lookups[$];
  lookup_t typed_result;
  logic    typed_valid;
  lookup_t seen, want, predicted;
  int      fail_count;
  int      idle_pct;
  bit      quiet;
  int      stall_left;

  function automatic lookup_t resolve_reference(input logic [PAGE_W-1:0] pg);
    lookup_t r;
    int      victim;
    int      f;
    r.miss = !page_mapped[pg];
    if (policy == POLICY_LRU) use_clock = use_clock + 1;
    if (page_mapped[pg]) begin
      r.frame = page_frame[pg];
    end else begin
      if (policy == POLICY_LRU) begin
        victim = -1;
        for (f = 0; f < FRAMES; f++)
          if (victim < 0 && !frame_busy[f]) victim = f;
        if (victim < 0) begin
          victim = 0;
          for (f = 1; f < FRAMES; f++)
            if (frame_last_use[f] < frame_last_use[victim]) victim = f;
        end
      end else begin
        victim = rr_next;
        rr_next = rr_next + 1'b1;
      end
      // a free frame has no previous owner to unmap
      if (frame_busy[victim]) page_mapped[frame_page[victim]] = 1'b0;
      frame_busy[victim] = 1'b1;
      frame_page[victim] = pg;
      page_mapped[pg]    = 1'b1;
      page_frame[pg]     = victim[FRAME_W-1:0];
      r.frame            = victim[FRAME_W-1:0];
    end
    if (policy == POLICY_LRU) frame_last_use[r.frame] = use_clock;
    return r;
  endfunction

  // predict at the input transaction; typed rows override the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predicted = resolve_reference(in_tdata[PAGE_W-1:0]);
      pending_lookups.push_back(typed_valid ? typed_result : predicted);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.frame = out_tdata[FRAME_W-1:0];
      seen.miss  = out_tdata[FRAME_W];
      if (pending_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result frame %0d miss %0b", $realtime, seen.frame,
                   seen.miss);
      end else begin
        want = pending_lookups.pop_front();
        if (seen.frame !== want.frame || seen.miss !== want.miss) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: frame exp %0d got %0d, miss exp %0b got %0b", $realtime,
                     want.frame, seen.frame, want.miss, seen.miss);
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-PAGE_W){1'b0}}, pg};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
  endtask

  task automatic write_policy(input policy_t p);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    policy = p;
  endtask

  stim_row_t directed_rows [24] = '{
    '{ROW_REF, 6'd0,  1'b1, 3'd0, 1'b1},   // first reference lands in frame 0
    '{ROW_REF, 6'd63, 1'b1, 3'd1, 1'b1},
    '{ROW_REF, 6'd0,  1'b1, 3'd0, 1'b0},   // hit
    '{ROW_REF, 6'd1,  1'b1, 3'd2, 1'b1},
    '{ROW_REF, 6'd2,  1'b1, 3'd3, 1'b1},
    '{ROW_REF, 6'd3,  1'b1, 3'd4, 1'b1},
    '{ROW_REF, 6'd4,  1'b1, 3'd5, 1'b1},
    '{ROW_REF, 6'd5,  1'b1, 3'd6, 1'b1},
    '{ROW_REF, 6'd6,  1'b1, 3'd7, 1'b1},   // all frames now busy
    '{ROW_REF, 6'd7,  1'b0, 3'd0, 1'b0},   // oldest stamp evicted
    '{ROW_REF, 6'd63, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG, 6'd1,  1'b0, 3'd0, 1'b0},
    '{ROW_REF, 6'd42, 1'b1, 3'd0, 1'b1},   // round robin starts at frame 0
    '{ROW_REF, 6'd21, 1'b1, 3'd1, 1'b1},
    '{ROW_REF, 6'd42, 1'b1, 3'd0, 1'b0},
    '{ROW_REF, 6'd7,  1'b0, 3'd0, 1'b0},
    '{ROW_CFG, 6'd0,  1'b0, 3'd0, 1'b0},
    '{ROW_REF, 6'd0,  1'b0, 3'd0, 1'b0},   // stamps untouched during FIFO
    '{ROW_REF, 6'd42, 1'b0, 3'd0, 1'b0},
    '{ROW_REF, 6'd63, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG, 6'd1,  1'b0, 3'd0, 1'b0},
    '{ROW_REF, 6'd0,  1'b0, 3'd0, 1'b0},
    '{ROW_REF, 6'd21, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG, 6'd0,  1'b0, 3'd0, 1'b0}
  };

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                i, n, p;
    int                ws_base, ws_size;
    int                phase_pct [6];
    logic [PAGE_W-1:0] pg;
    phase_pct = '{30, 50, 0, 20, 60, 0};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    typed_valid = 1'b0;
    typed_result = '0;
    fail_count  = 0;
    idle_pct    = 25;
    quiet       = 1'b0;
    stall_left  = 0;
    for (i = 0; i < PAGES; i++) begin
      page_mapped[i] = 1'b0;
      page_frame[i]  = '0;
    end
    for (i = 0; i < FRAMES; i++) begin
      frame_busy[i]     = 1'b0;
      frame_page[i]     = '0;
      frame_last_use[i] = '0;
    end
    rr_next   = '0;
    use_clock = '0;
    policy    = POLICY_LRU;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_policy(policy_t'(directed_rows[r].page[0]));
      end else begin
        typed_valid  <= directed_rows[r].typed;
        typed_result <= '{directed_rows[r].frame, directed_rows[r].miss};
        send_page(directed_rows[r].page);
        sender_gap();
      end
    end
    typed_valid <= 1'b0;

    // random part: mostly a drifting working set so hits and evictions both occur
    ws_base = 0;
    ws_size = 6;
    for (p = 0; p < 6; p++) begin
      idle_pct = phase_pct[p];
      quiet    = (p == 5);
      write_policy(p < 4 ? policy_t'(p % 2) : policy_t'($urandom_range(0, 1)));
      for (n = 0; n < 300; n++) begin
        if (n % 40 == 0) begin
          ws_base = $urandom_range(0, PAGES - 1);
          ws_size = $urandom_range(4, 14);
        end
        if ($urandom_range(0, 99) < 70)
          pg = PAGE_W'((ws_base + $urandom_range(0, ws_size - 1)) % PAGES);
        else
          pg = PAGE_W'($urandom_range(0, PAGES - 1));
        send_page(pg);
        if (p == 1 && n == 150) wait_drained();
        else sender_gap();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
